// ----- design/three_wire_serial_master_macros.svh -----
// ----------------------------------------------------------------------------
// Three-wire serial master assertion macros
// Shared property wrappers, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// Implication that must hold in the same cycle.
`define TWS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TWS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master package
// Request codes, register map, command and result words, reset values.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int MAX_BURST_DEFAULT = 8;
  localparam int QUEUE_DEPTH       = 4;
  localparam int TIMER_W           = 10;
  localparam int ADDR_W            = 3;
  localparam int DATA_W            = 32;

  localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET  = 10'd50;
  localparam logic [TIMER_W-1:0] ENABLE_GUARD_RESET = 10'd100;

  // Request type codes on the input word
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Register indexes (byte address divided by four)
  localparam logic [0:0] REG_HALF_PERIOD  = 1'b0;
  localparam logic [0:0] REG_ENABLE_GUARD = 1'b1;

  localparam logic [7:0] READ_FLAG = 8'h01;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_LOAD,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic [3:0] count;
    logic       io;
  } cmd_t;

  typedef struct packed {
    logic [TIMER_W-1:0] half_period;
    logic [TIMER_W-1:0] enable_guard;
  } cfg_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       busy_res;
    logic       rejected;
  } rsp_t;

endpackage

// ----- design/tws_front.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master request front end
// Accepts request words and classifies them into queue commands.
// ----------------------------------------------------------------------------
module tws_front
  import tws_pkg::*;
(
  input  logic       req_valid,
  input  logic [1:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       last,
  input  logic [3:0] read_count,
  input  logic       io_in,
  input  logic       full,
  output logic       push,
  output cmd_t       cmd
);

  assign push = req_valid && !full;

  always_comb begin
    cmd.data  = tx_byte;
    cmd.last  = last;
    cmd.io    = io_in;
    // a zero count reads one byte
    cmd.count = (read_count == 4'd0) ? 4'd1 : read_count;
    unique case (req_type)
      REQ_TICK: cmd.kind = KIND_TICK;
      REQ_LOAD: cmd.kind = KIND_LOAD;
      REQ_READ: begin
        cmd.kind = KIND_READ;
        cmd.data = tx_byte | READ_FLAG;
      end
      default:  cmd.kind = KIND_NONE;
    endcase
  end

endmodule

// ----- design/tws_queue.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master command queue
// Short FIFO between the front end and the bus engine.
// ----------------------------------------------------------------------------
module tws_queue
  import tws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- design/tws_engine.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master bus engine
// Runs the send buffer and pin timing, one queued command per cycle while results are not stalled.
// ----------------------------------------------------------------------------
module tws_engine
  import tws_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic nonempty,
  input  cmd_t cmd,
  output logic pop,
  input  logic rsp_stall,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int DEPTH = MAX_BURST + 1;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_BURST + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_HIGH,
    PH_LOW,
    PH_HOLD
  } phase_t;

  logic [7:0]         send_buf [DEPTH];
  phase_t             phase, phase_next;
  logic [BW-1:0]      fill, fill_next;
  logic [BW-1:0]      byte_idx, byte_idx_next;
  logic [2:0]         bit_idx, bit_idx_next;
  logic [TIMER_W-1:0] tick, tick_next;
  logic [7:0]         shift, shift_next;
  logic [RW-1:0]      reads_left, reads_left_next;
  logic               pin_ce, pin_ce_next;
  logic               pin_clk, pin_clk_next;
  logic               pin_io, pin_io_next;
  logic               pin_drive, pin_drive_next;
  rsp_t               rsp_next;

  logic               busy;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic               start;
  logic [RW-1:0]      start_reads;
  logic               do_bit;
  logic [TIMER_W-1:0] tick_inc;

  assign busy     = (phase != PH_IDLE);
  assign pop      = nonempty && (!rsp_valid || !rsp_stall);
  assign tick_inc = tick + 1'b1;

  always_comb begin
    phase_next      = phase;
    fill_next       = fill;
    byte_idx_next   = byte_idx;
    bit_idx_next    = bit_idx;
    tick_next       = tick;
    shift_next      = shift;
    reads_left_next = reads_left;
    pin_ce_next     = pin_ce;
    pin_clk_next    = pin_clk;
    pin_io_next     = pin_io;
    pin_drive_next  = pin_drive;
    wr_en           = 1'b0;
    wr_idx          = '0;
    start           = 1'b0;
    start_reads     = '0;
    do_bit          = 1'b0;
    rsp_next        = '0;

    if (pop) begin
      unique case (cmd.kind)
        KIND_LOAD: begin
          if (busy) begin
            rsp_next.rejected = 1'b1;
          end else if (fill < BW'(DEPTH)) begin
            wr_en     = 1'b1;
            wr_idx    = fill[IW-1:0];
            fill_next = fill + 1'b1;
            // a full buffer starts the transfer on its own
            if (cmd.last || fill_next == BW'(DEPTH)) begin
              start = 1'b1;
            end
          end else begin
            rsp_next.rejected = 1'b1;
          end
        end
        KIND_READ: begin
          if (busy) begin
            rsp_next.rejected = 1'b1;
          end else begin
            wr_en       = 1'b1;
            wr_idx      = '0;
            fill_next   = BW'(1);
            start       = 1'b1;
            start_reads = (32'(cmd.count) > MAX_BURST) ? RW'(MAX_BURST) : RW'(cmd.count);
          end
        end
        KIND_TICK: begin
          if (busy) begin
            tick_next = tick_inc;
            unique case (phase)
              PH_SETUP: begin
                if (tick_inc >= cfg.enable_guard) begin
                  do_bit = 1'b1;
                end
              end
              PH_HIGH: begin
                if (tick_inc >= cfg.half_period) begin
                  pin_clk_next = 1'b0;
                  tick_next    = '0;
                  phase_next   = PH_LOW;
                end
              end
              PH_LOW: begin
                if (tick_inc >= cfg.half_period) begin
                  if (byte_idx >= fill && bit_idx == 3'd7) begin
                    rsp_next.rd_byte  = shift;
                    rsp_next.rd_valid = 1'b1;
                    rsp_next.rd_last  = (reads_left <= RW'(1));
                    if (reads_left != '0) begin
                      reads_left_next = reads_left - 1'b1;
                    end
                  end
                  if (bit_idx == 3'd7) begin
                    bit_idx_next  = '0;
                    byte_idx_next = byte_idx + 1'b1;
                  end else begin
                    bit_idx_next = bit_idx + 1'b1;
                  end
                  if (byte_idx_next < fill || reads_left_next != '0) begin
                    do_bit = 1'b1;
                  end else begin
                    tick_next  = '0;
                    phase_next = PH_HOLD;
                  end
                end
              end
              PH_HOLD: begin
                if (tick_inc >= cfg.enable_guard) begin
                  phase_next      = PH_IDLE;
                  fill_next       = '0;
                  bit_idx_next    = '0;
                  byte_idx_next   = '0;
                  tick_next       = '0;
                  reads_left_next = '0;
                  pin_ce_next     = 1'b0;
                  pin_clk_next    = 1'b0;
                  pin_io_next     = 1'b0;
                  pin_drive_next  = 1'b1;
                end
              end
              default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
              end
            endcase
          end
        end
        default: ;
      endcase

      if (start) begin
        reads_left_next = start_reads;
        bit_idx_next    = '0;
        byte_idx_next   = '0;
        tick_next       = '0;
        shift_next      = '0;
        phase_next      = PH_SETUP;
        pin_ce_next     = 1'b1;
        pin_clk_next    = 1'b0;
        pin_io_next     = 1'b0;
        pin_drive_next  = 1'b1;
      end

      // raise the clock on the next bit: drive from the buffer or sample the line
      if (do_bit) begin
        if (byte_idx_next < fill_next) begin
          pin_drive_next = 1'b1;
          pin_io_next    = send_buf[byte_idx_next[IW-1:0]][bit_idx_next];
        end else begin
          pin_drive_next = 1'b0;
          if (bit_idx_next == 3'd0) begin
            shift_next = '0;
          end
          if (cmd.io) begin
            shift_next[bit_idx_next] = 1'b1;
          end
        end
        pin_clk_next = 1'b1;
        tick_next    = '0;
        phase_next   = PH_HIGH;
      end
    end

    rsp_next.chip_enable  = pin_ce_next;
    rsp_next.serial_clock = pin_clk_next;
    rsp_next.io_out       = pin_io_next;
    rsp_next.io_drive     = pin_drive_next;
    rsp_next.busy_res     = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      fill       <= '0;
      byte_idx   <= '0;
      bit_idx    <= '0;
      tick       <= '0;
      shift      <= '0;
      reads_left <= '0;
      pin_ce     <= 1'b0;
      pin_clk    <= 1'b0;
      pin_io     <= 1'b0;
      pin_drive  <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      fill       <= fill_next;
      byte_idx   <= byte_idx_next;
      bit_idx    <= bit_idx_next;
      tick       <= tick_next;
      shift      <= shift_next;
      reads_left <= reads_left_next;
      pin_ce     <= pin_ce_next;
      pin_clk    <= pin_clk_next;
      pin_io     <= pin_io_next;
      pin_drive  <= pin_drive_next;
      if (pop) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (pop) begin
      rsp <= rsp_next;
    end
    if (wr_en) begin
      send_buf[wr_idx] <= cmd.data;
    end
  end

endmodule

// ----- design/three_wire_serial_master.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master
// Chip enable, serial clock and bidirectional data master for a serial clock
// chip, driven by tick, write load and read request words.
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  request   req_valid / req_stall  req_type tx_byte last read_count io_in
//  result    rsp_valid / rsp_stall  pins, rd_byte rd_valid rd_last busy_res rejected
//  config    psel penable pwrite    paddr pwdata prdata pready
//
//  One request word per cycle while req_stall is low; each gives one result word.
//  A four-entry command queue feeds the engine, which retires one word a cycle
//  into its output register while that register is not stalled.
//  Reset is synchronous: pins low with the line driven, queue empty.
//  req_stall rises only while the queue is full; rsp_stall holds the output
//  register and backs the queue up.
// ----------------------------------------------------------------------------
`include "three_wire_serial_master_macros.svh"

module three_wire_serial_master
  import tws_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic              last,
  input  logic [3:0]        read_count,
  input  logic              io_in,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic              chip_enable,
  output logic              serial_clock,
  output logic              io_out,
  output logic              io_drive,
  output logic [7:0]        rd_byte,
  output logic              rd_valid,
  output logic              rd_last,
  output logic              busy_res,
  output logic              rejected,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic [0:0] reg_idx;
  logic       push;
  cmd_t       push_cmd;
  logic       full;
  logic       nonempty;
  cmd_t       head;
  logic       pop;
  rsp_t       rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period  <= HALF_PERIOD_RESET;
      cfg.enable_guard <= ENABLE_GUARD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_HALF_PERIOD:  cfg.half_period  <= pwdata[TIMER_W-1:0];
        REG_ENABLE_GUARD: cfg.enable_guard <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HALF_PERIOD:  prdata = DATA_W'(cfg.half_period);
      REG_ENABLE_GUARD: prdata = DATA_W'(cfg.enable_guard);
      default:          prdata = '0;
    endcase
  end

  assign req_stall = full;

  tws_front u_front (
    .req_valid  (req_valid),
    .req_type   (req_type),
    .tx_byte    (tx_byte),
    .last       (last),
    .read_count (read_count),
    .io_in      (io_in),
    .full       (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  tws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  tws_engine #(
    .MAX_BURST (MAX_BURST)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nonempty  (nonempty),
    .cmd       (head),
    .pop       (pop),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign chip_enable  = rsp.chip_enable;
  assign serial_clock = rsp.serial_clock;
  assign io_out       = rsp.io_out;
  assign io_drive     = rsp.io_drive;
  assign rd_byte      = rsp.rd_byte;
  assign rd_valid     = rsp.rd_valid;
  assign rd_last      = rsp.rd_last;
  assign busy_res     = rsp.busy_res;
  assign rejected     = rsp.rejected;

  `TWS_ASSERT_IMPL(a_busy_ce, rsp_valid, busy_res == chip_enable, "busy and chip enable differ")
  `TWS_ASSERT_IMPL(a_idle_pins, rsp_valid && !chip_enable, !serial_clock && io_drive, "idle pins not parked")
  `TWS_ASSERT_IMPL(a_rd_released, rsp_valid && rd_valid, !io_drive && chip_enable, "read byte while driving")
  `TWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rd_byte), "stalled word lost")

endmodule

// ----- bench/tws_checker.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master checker
// Watches the request, result and register ports and keeps its own model of
// the link. Every accepted request word yields one expected result word. Each
// accepted result word is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module tws_checker
  import tws_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic              last,
  input  logic [3:0]        read_count,
  input  logic              io_in,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic              chip_enable,
  input  logic              serial_clock,
  input  logic              io_out,
  input  logic              io_drive,
  input  logic [7:0]        rd_byte,
  input  logic              rd_valid,
  input  logic              rd_last,
  input  logic              busy_res,
  input  logic              rejected,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int unsigned       pending,
  output int unsigned       failures
);

  localparam int BUF_DEPTH = MAX_BURST_DEFAULT + 1;

  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_SETUP,
    LINK_HIGH,
    LINK_LOW,
    LINK_HOLD
  } link_t;

  logic [TIMER_W-1:0] half;
  logic [TIMER_W-1:0] guard;
  logic [7:0]         send_bytes [BUF_DEPTH];
  logic [3:0]         fill;
  logic [3:0]         byte_idx;
  logic [3:0]         reads_left;
  logic [2:0]         bit_idx;
  logic [TIMER_W-1:0] ticks;
  logic [7:0]         shift;
  link_t              link;
  logic               pin_ce;
  logic               pin_clk;
  logic               pin_io;
  logic               pin_drive;
  rsp_t               due_words [$];

  task automatic release_pins();
    pin_ce    = 1'b0;
    pin_clk   = 1'b0;
    pin_io    = 1'b0;
    pin_drive = 1'b1;
  endtask

  task automatic reset_link();
    half  = HALF_PERIOD_RESET;
    guard = ENABLE_GUARD_RESET;
    for (int i = 0; i < BUF_DEPTH; i++)
      send_bytes[i] = 8'h00;
    fill       = '0;
    byte_idx   = '0;
    reads_left = '0;
    bit_idx    = '0;
    ticks      = '0;
    shift      = '0;
    link       = LINK_IDLE;
    release_pins();
  endtask

  task automatic start_link(input logic [3:0] reads);
    reads_left = reads;
    bit_idx    = '0;
    byte_idx   = '0;
    ticks      = '0;
    shift      = '0;
    link       = LINK_SETUP;
    pin_ce     = 1'b1;
    pin_clk    = 1'b0;
    pin_io     = 1'b0;
    pin_drive  = 1'b1;
  endtask

  // Raise the clock for the next bit: drive a command bit or sample the line.
  task automatic clock_bit(input logic io);
    if (byte_idx < fill && byte_idx < BUF_DEPTH) begin
      pin_drive = 1'b1;
      pin_io    = send_bytes[byte_idx][bit_idx];
    end else begin
      pin_drive = 1'b0;
      if (bit_idx == 3'd0)
        shift = 8'h00;
      if (io)
        shift[bit_idx] = 1'b1;
    end
    pin_clk = 1'b1;
    ticks   = '0;
    link    = LINK_HIGH;
  endtask

  task automatic step_link(input logic [1:0] rq, input logic [7:0] data, input logic fin,
                           input logic [3:0] count_in, input logic io, output rsp_t word);
    logic [3:0] count;
    logic       busy;
    word  = '0;
    count = count_in;
    busy  = (link != LINK_IDLE);
    if (rq == REQ_LOAD || rq == REQ_READ) begin
      if (busy) begin
        word.rejected = 1'b1;
      end else if (rq == REQ_LOAD) begin
        if (fill < BUF_DEPTH) begin
          send_bytes[fill] = data;
          fill = fill + 4'd1;
          if (fin || fill >= BUF_DEPTH)
            start_link(4'd0);
        end else begin
          word.rejected = 1'b1;
        end
      end else begin
        if (count == 4'd0)
          count = 4'd1;
        if (count > MAX_BURST_DEFAULT)
          count = 4'(MAX_BURST_DEFAULT);
        // a read drops any write bytes still waiting
        send_bytes[0] = data | READ_FLAG;
        fill = 4'd1;
        start_link(count);
      end
    end else if (rq == REQ_TICK && busy) begin
      ticks = ticks + 1'b1;
      case (link)
        LINK_SETUP: begin
          if (ticks >= guard)
            clock_bit(io);
        end
        LINK_HIGH: begin
          if (ticks >= half) begin
            pin_clk = 1'b0;
            ticks   = '0;
            link    = LINK_LOW;
          end
        end
        LINK_LOW: begin
          if (ticks >= half) begin
            if (byte_idx >= fill && bit_idx == 3'd7) begin
              word.rd_byte  = shift;
              word.rd_valid = 1'b1;
              word.rd_last  = (reads_left <= 4'd1);
              if (reads_left > 4'd0)
                reads_left = reads_left - 4'd1;
            end
            if (bit_idx == 3'd7) begin
              bit_idx  = 3'd0;
              byte_idx = byte_idx + 4'd1;
            end else begin
              bit_idx = bit_idx + 3'd1;
            end
            if (byte_idx < fill || reads_left > 4'd0) begin
              clock_bit(io);
            end else begin
              ticks = '0;
              link  = LINK_HOLD;
            end
          end
        end
        LINK_HOLD: begin
          if (ticks >= guard) begin
            link       = LINK_IDLE;
            fill       = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            ticks      = '0;
            reads_left = '0;
            release_pins();
          end
        end
        default: begin
          link  = LINK_IDLE;
          ticks = '0;
        end
      endcase
    end
    word.chip_enable  = pin_ce;
    word.serial_clock = pin_clk;
    word.io_out       = pin_io;
    word.io_drive     = pin_drive;
    word.busy_res     = (link != LINK_IDLE);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      reset_link();
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[ADDR_W-1:2] == REG_HALF_PERIOD)
          half = pwdata[TIMER_W-1:0];
        else if (paddr[ADDR_W-1:2] == REG_ENABLE_GUARD)
          guard = pwdata[TIMER_W-1:0];
      end
      if (req_valid && !req_stall) begin
        step_link(req_type, tx_byte, last, read_count, io_in, want);
        due_words.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_words.size() == 0) begin
          failures++;
          $display("%0t: result word mismatch: expected none, actual pins %b%b%b%b rd_byte %0h",
                   $time, chip_enable, serial_clock, io_out, io_drive, rd_byte);
        end else begin
          want = due_words.pop_front();
          check_field("chip_enable", 8'(want.chip_enable), 8'(chip_enable));
          check_field("serial_clock", 8'(want.serial_clock), 8'(serial_clock));
          check_field("io_out", 8'(want.io_out), 8'(io_out));
          check_field("io_drive", 8'(want.io_drive), 8'(io_drive));
          check_field("rd_byte", want.rd_byte, rd_byte);
          check_field("rd_valid", 8'(want.rd_valid), 8'(rd_valid));
          check_field("rd_last", 8'(want.rd_last), 8'(rd_last));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
          check_field("rejected", 8'(want.rejected), 8'(rejected));
        end
      end
    end
    pending = due_words.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master testbench
// Drives tick, load and read words with random gaps and result stalls, walks
// the timing registers through small and extreme settings, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import tws_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         RANDOM_PHASES = 4;
  localparam int         PHASE_WORDS   = 40;
  localparam int         LONG_HOLD     = 60;
  localparam int         RESET_TICKS   = 110;
  localparam int         EXTREME_TICKS = 40;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [1:0]        req_type;
  logic [7:0]        tx_byte;
  logic              last;
  logic [3:0]        read_count;
  logic              io_in;
  logic              rsp_valid;
  logic              rsp_stall;
  logic              chip_enable;
  logic              serial_clock;
  logic              io_out;
  logic              io_drive;
  logic [7:0]        rd_byte;
  logic              rd_valid;
  logic              rd_last;
  logic              busy_res;
  logic              rejected;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned        pending;
  int unsigned        failures;
  bit                 calm;
  bit                 long_hold;
  int                 sent;
  logic [TIMER_W-1:0] cur_half;
  logic [TIMER_W-1:0] cur_guard;

  always #1 clk = ~clk;

  three_wire_serial_master dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .tx_byte      (tx_byte),
    .last         (last),
    .read_count   (read_count),
    .io_in        (io_in),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .chip_enable  (chip_enable),
    .serial_clock (serial_clock),
    .io_out       (io_out),
    .io_drive     (io_drive),
    .rd_byte      (rd_byte),
    .rd_valid     (rd_valid),
    .rd_last      (rd_last),
    .busy_res     (busy_res),
    .rejected     (rejected),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  tws_checker chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .tx_byte      (tx_byte),
    .last         (last),
    .read_count   (read_count),
    .io_in        (io_in),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .chip_enable  (chip_enable),
    .serial_clock (serial_clock),
    .io_out       (io_out),
    .io_drive     (io_drive),
    .rd_byte      (rd_byte),
    .rd_valid     (rd_valid),
    .rd_last      (rd_last),
    .busy_res     (busy_res),
    .rejected     (rejected),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending      (pending),
    .failures     (failures)
  );

  initial begin : watchdog
    #3000000;
    $display("FAIL three_wire_serial_master");
    $finish;
  end

  // Result side: random stall before each word, plus one long hold on request.
  initial begin : receiver
    int w;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      w = calm ? 0 : $urandom_range(0, 5);
      rsp_stall <= (w > 0);
      if (w > 0) begin
        repeat (w) @(negedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input logic [1:0] rq, input logic [7:0] data, input logic fin,
                            input logic [3:0] count, input logic io);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= rq;
    tx_byte    <= data;
    last       <= fin;
    read_count <= count;
    io_in      <= io;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) offer_word(REQ_TICK, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
  endtask

  // Ticks a transfer of the given byte count needs at the current timing.
  function automatic int transfer_span(input int bytes);
    int h;
    int g;
    h = (cur_half == 0) ? 1 : cur_half;
    g = (cur_guard == 0) ? 1 : cur_guard;
    return 2 * g + 16 * h * bytes + 2;
  endfunction

  // Hold off until every word in flight has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [0:0] idx, input logic [TIMER_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [TIMER_W-1:0] h, input logic [TIMER_W-1:0] g);
    drain();
    reg_write(REG_HALF_PERIOD, h);
    reg_write(REG_ENABLE_GUARD, g);
    cur_half  = h;
    cur_guard = g;
  endtask

  // One write, read or noise burst followed by ticks, with stray requests mixed in.
  task automatic random_transfer();
    int   kind;
    int   n;
    int   i;
    int   count;
    int   bytes;
    int   span;
    int   t;
    logic fin;
    calm = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      n = $urandom_range(1, 9);
      for (i = 0; i < n; i++) begin
        if (i == n - 1)
          fin = (n < 9) ? 1'b1 : 1'($urandom_range(0, 1));
        else
          fin = ($urandom_range(0, 15) == 0);
        offer_word(REQ_LOAD, 8'($urandom), fin, 4'($urandom), 1'($urandom));
      end
      bytes = n;
    end else if (kind < 8) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3))
          offer_word(REQ_LOAD, 8'($urandom), 1'b0, 4'($urandom), 1'($urandom));
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      offer_word(REQ_READ, 8'($urandom), 1'($urandom), 4'(count), 1'($urandom));
      if (count == 0)
        count = 1;
      if (count > MAX_BURST_DEFAULT)
        count = MAX_BURST_DEFAULT;
      bytes = 1 + count;
    end else begin
      repeat ($urandom_range(1, 4))
        offer_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 4'($urandom),
                   1'($urandom));
      bytes = MAX_BURST_DEFAULT + 1;
    end
    span = transfer_span(bytes);
    t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : span + $urandom_range(0, 3);
    repeat (t) begin
      if ($urandom_range(0, 24) == 0)
        offer_word(2'($urandom_range(REQ_LOAD, REQ_READ)), 8'($urandom), 1'($urandom),
                   4'($urandom), 1'($urandom));
      else
        tick_run(1);
    end
  endtask

  initial begin : stimulus
    int start;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_TICK;
    tx_byte    = 8'h00;
    last       = 1'b0;
    read_count = 4'd0;
    io_in      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    sent       = 0;
    cur_half   = HALF_PERIOD_RESET;
    cur_guard  = ENABLE_GUARD_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single read at the reset timing, past the end of setup
    offer_word(REQ_READ, 8'h80, 1'b0, 4'd1, 1'b1);
    tick_run(RESET_TICKS);

    // zero timing acts as one; finish the read at the fast timing
    set_timing('0, '0);
    tick_run(transfer_span(2));
    offer_word(REQ_TICK, 8'hFF, 1'b1, 4'hF, 1'b1);
    offer_word(REQ_UNUSED, 8'hFF, 1'b1, 4'hF, 1'b1);
    offer_word(REQ_LOAD, 8'h00, 1'b0, 4'h0, 1'b0);
    offer_word(REQ_LOAD, 8'hFF, 1'b0, 4'hF, 1'b1);
    // read drops the pending loads; count zero reads one byte
    offer_word(REQ_READ, 8'hFE, 1'b0, 4'h0, 1'b0);
    tick_run(3);
    offer_word(REQ_LOAD, 8'h3C, 1'b1, 4'h1, 1'b1);
    offer_word(REQ_READ, 8'hC3, 1'b0, 4'h8, 1'b0);
    offer_word(REQ_UNUSED, 8'h00, 1'b0, 4'h0, 1'b0);
    tick_run(transfer_span(2));
    // count above the burst limit saturates
    offer_word(REQ_READ, 8'h00, 1'b1, 4'hF, 1'b1);
    tick_run(transfer_span(MAX_BURST_DEFAULT + 1));
    // filling the buffer starts the transfer without last
    for (int i = 0; i < MAX_BURST_DEFAULT + 1; i++)
      offer_word(REQ_LOAD, 8'h01 << (i % 8), 1'b0, 4'h0, 1'b0);
    tick_run(transfer_span(MAX_BURST_DEFAULT + 1));
    offer_word(REQ_LOAD, 8'hA5, 1'b1, 4'h8, 1'b1);
    tick_run(transfer_span(1));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_timing(TIMER_W'($urandom_range(0, 2)), TIMER_W'($urandom_range(0, 4)));
      long_hold = 1'b1;
      start = sent;
      while (sent - start < PHASE_WORDS)
        random_transfer();
    end

    calm = 1'b0;
    // top timing values: a write sits in setup, then the timing speeds up
    set_timing(10'd1023, 10'd1023);
    offer_word(REQ_LOAD, 8'h5A, 1'b1, 4'h0, 1'b0);
    tick_run(EXTREME_TICKS);
    set_timing('0, '0);
    tick_run(transfer_span(1));
    set_timing(10'd1, 10'd1);
    random_transfer();

    drain();
    repeat (10) @(negedge clk);
    if (failures == 0)
      $display("PASS three_wire_serial_master");
    else
      $display("FAIL three_wire_serial_master");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tws_pkg.sv
design/tws_front.sv
design/tws_queue.sv
design/tws_engine.sv
design/three_wire_serial_master.sv
bench/tws_checker.sv
bench/tb_top.sv
